[design/utlb_pkg.sv]
// ----------------------------------------------------------------------------
// utlb_pkg
// shared types, constants and helpers for the utlb memory-mapped array port
// ----------------------------------------------------------------------------
package utlb_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam int VPN_W  = 22;
    localparam int ASID_W = 8;
    localparam int PPN_W  = 19;
    localparam int DATA_W = 32;
    localparam int CMD_W  = 2;
    localparam int EIDX_W = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_AA_WRITE  = 2'd0,
        CMD_AA_READ   = 2'd1,
        CMD_DA1_WRITE = 2'd2,
        CMD_DA1_READ  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [VPN_W-1:0]  vpn;
        logic [ASID_W-1:0] asid;
        logic              valid;
        logic              dirty;
        logic [PPN_W-1:0]  ppn;
        logic [1:0]        size;
        logic [1:0]        prot;
        logic              cacheable;
        logic              shared;
        logic              wt;
    } entry_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
    } store_req_t;

    // vpn bits kept in the compare for each page size code
    function automatic logic [VPN_W-1:0] vpn_mask(input logic [1:0] size);
        logic [VPN_W-1:0] m;
        case (size)
            2'd0:    m = 22'h3fffff;
            2'd1:    m = 22'h3ffffc;
            2'd2:    m = 22'h3fffc0;
            2'd3:    m = 22'h3ffc00;
            default: m = 22'h3fffff;
        endcase
        return m;
    endfunction

endpackage

[design/utlb_store.sv]
// ----------------------------------------------------------------------------
// utlb_store
// entry memory with one write and one registered read port, plus per-entry
// valid bits so that unwritten entries read as all zero after reset
// ----------------------------------------------------------------------------
module utlb_store (
    input  logic                clk,
    input  logic                rst_n,
    input  utlb_pkg::store_req_t req,
    output utlb_pkg::entry_t    rd_data
);
    import utlb_pkg::*;

    entry_t               store_mem [ENTRIES];
    logic [ENTRIES-1:0]   written_reg;
    entry_t               rd_data_reg;
    logic                 rd_written_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            store_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= store_mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                written_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_written_reg <= written_reg[req.rd_addr];
            end
        end
    end

    // never-written entries read as zero after reset
    assign rd_data = rd_written_reg ? rd_data_reg : '0;

endmodule

[design/utlb_match.sv]
// ----------------------------------------------------------------------------
// utlb_match
// shared compare unit: vpn under the entry's page-size mask, and asid
// ----------------------------------------------------------------------------
module utlb_match (
    input  utlb_pkg::entry_t                  ent,
    input  logic [utlb_pkg::VPN_W-1:0]        vpn,
    input  logic [utlb_pkg::ASID_W-1:0]       asid,
    output logic                              match
);
    import utlb_pkg::*;

    logic [VPN_W-1:0] keep;

    always_comb
    begin
        keep  = vpn_mask(ent.size);
        match = (((ent.vpn ^ vpn) & keep) == '0) && (ent.asid == asid);
    end

endmodule

[design/utlb_ctrl.sv]
// ----------------------------------------------------------------------------
// utlb_ctrl
// sequencer: indexed read-modify-write and the in-order associative scan
// ----------------------------------------------------------------------------
module utlb_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [utlb_pkg::CMD_W-1:0]        command,
    input  logic [utlb_pkg::EIDX_W-1:0]       entry_index,
    input  logic                              associative,
    input  logic [utlb_pkg::DATA_W-1:0]       write_data,
    input  logic [utlb_pkg::ASID_W-1:0]       current_asid,
    output utlb_pkg::store_req_t              req,
    input  utlb_pkg::entry_t                  rd_data,
    output logic                              done,
    output logic [utlb_pkg::DATA_W-1:0]       read_data,
    output logic                              hit,
    output logic                              error
);
    import utlb_pkg::*;

    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(ENTRIES);

    state_t              state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [DATA_W-1:0]   wdata_reg, wdata_next;
    logic [CNT_W-1:0]    issue_cnt_reg, issue_cnt_next;
    logic [IDX_W-1:0]    chk_addr_reg, chk_addr_next;
    logic                chk_vld_reg, chk_vld_next;
    logic [DATA_W-1:0]   rdata_reg, rdata_next;
    logic                hit_reg, hit_next;
    logic                err_reg, err_next;

    cmd_t                cmd_in;
    logic                in_range;
    logic                scan_start;
    logic                ent_match;
    logic                match_hit;
    logic                issue;

    assign cmd_in     = cmd_t'(command);
    assign in_range   = (32'(entry_index) < ENTRIES);
    assign scan_start = (cmd_in == CMD_AA_WRITE) && associative;

    utlb_match u_match (
        .ent   (rd_data),
        .vpn   (wdata_reg[31:10]),
        .asid  (current_asid),
        .match (ent_match)
    );

    assign match_hit = chk_vld_reg && ent_match;
    assign issue     = (issue_cnt_reg < LAST_CNT) && !match_hit;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (scan_start)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if ((cmd_in == CMD_DA1_READ) || !in_range)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                if (match_hit || (!chk_vld_reg && (issue_cnt_reg == LAST_CNT)))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath next values
    always_comb
    begin
        req            = '0;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        wdata_next     = wdata_reg;
        issue_cnt_next = issue_cnt_reg;
        chk_addr_next  = chk_addr_reg;
        chk_vld_next   = chk_vld_reg;
        rdata_next     = rdata_reg;
        hit_next       = hit_reg;
        err_next       = err_reg;
        busy           = 1'b1;
        done           = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy        = 1'b0;
                req.rd_en   = start;
                req.rd_addr = entry_index[IDX_W-1:0];
                if (start)
                begin
                    cmd_next       = cmd_in;
                    idx_next       = entry_index[IDX_W-1:0];
                    wdata_next     = write_data;
                    issue_cnt_next = '0;
                    chk_vld_next   = 1'b0;
                    rdata_next     = '0;
                    hit_next       = 1'b0;
                    err_next       = (cmd_in == CMD_DA1_READ);
                end
            end
            ST_EXEC:
            begin
                req.wr_addr = idx_reg;
                req.wr_data = rd_data;
                case (cmd_reg)
                    CMD_AA_WRITE:
                    begin
                        req.wr_en         = 1'b1;
                        req.wr_data.vpn   = wdata_reg[31:10];
                        req.wr_data.dirty = wdata_reg[9];
                        req.wr_data.valid = wdata_reg[8];
                        req.wr_data.asid  = wdata_reg[7:0];
                    end
                    CMD_AA_READ:
                    begin
                        rdata_next = {rd_data.vpn, rd_data.dirty, rd_data.valid,
                                      rd_data.asid};
                    end
                    CMD_DA1_WRITE:
                    begin
                        req.wr_en             = 1'b1;
                        req.wr_data.ppn       = wdata_reg[28:10];
                        req.wr_data.valid     = wdata_reg[8];
                        req.wr_data.size      = {wdata_reg[7], wdata_reg[4]};
                        req.wr_data.prot      = wdata_reg[6:5];
                        req.wr_data.cacheable = wdata_reg[3];
                        req.wr_data.dirty     = wdata_reg[2];
                        req.wr_data.shared    = wdata_reg[1];
                        req.wr_data.wt        = wdata_reg[0];
                    end
                    default:
                    begin
                        req.wr_en = 1'b0;
                    end
                endcase
            end
            ST_SCAN:
            begin
                // one read issued and one entry compared per cycle
                req.rd_en     = issue;
                req.rd_addr   = issue_cnt_reg[IDX_W-1:0];
                chk_addr_next = issue_cnt_reg[IDX_W-1:0];
                chk_vld_next  = issue;
                if (issue)
                begin
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end
                req.wr_addr       = chk_addr_reg;
                req.wr_data       = rd_data;
                req.wr_data.dirty = wdata_reg[9];
                req.wr_data.valid = wdata_reg[8];
                if (match_hit)
                begin
                    req.wr_en = 1'b1;
                    hit_next  = 1'b1;
                end
            end
            ST_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issue_cnt_reg <= '0;
            chk_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            chk_vld_reg   <= chk_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        idx_reg      <= idx_next;
        wdata_reg    <= wdata_next;
        chk_addr_reg <= chk_addr_next;
        rdata_reg    <= rdata_next;
        hit_reg      <= hit_next;
        err_reg      <= err_next;
    end

    assign read_data = rdata_reg;
    assign hit       = hit_reg;
    assign error     = err_reg;

endmodule

[design/utlb_mapped_array_access.sv]
// ----------------------------------------------------------------------------
// utlb_mapped_array_access
// memory-mapped address array / data array 1 port of a unified tlb
// ----------------------------------------------------------------------------
//
//  channel   handshake          payload
//  -------   ---------          -------
//  input     start & !busy      command, entry_index, associative, write_data
//  result    done (one cycle)   read_data, hit, error
//  config    cfg_we             cfg_wdata (current asid)
//
//  indexed accesses go from accept to done through memory read, modify
//  and write back, and result
//  an associative write scans the entry memory one entry per cycle through
//  one compare unit, in index order, and stops at the first matching entry
//  a data array 1 read or an out-of-range index skips modify and write back
//  reset clears the entries at once through per-entry valid bits
//  results cannot be stalled: done is high for exactly one cycle per item
//
module utlb_mapped_array_access (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [utlb_pkg::CMD_W-1:0]        command,
    input  logic [utlb_pkg::EIDX_W-1:0]       entry_index,
    input  logic                              associative,
    input  logic [utlb_pkg::DATA_W-1:0]       write_data,
    output logic                              done,
    output logic [utlb_pkg::DATA_W-1:0]       read_data,
    output logic                              hit,
    output logic                              error,
    input  logic                              cfg_we,
    input  logic [utlb_pkg::ASID_W-1:0]       cfg_wdata
);
    import utlb_pkg::*;

    // asid used by associative writes
    logic [ASID_W-1:0] asid_reg;
    logic [ASID_W-1:0] asid_next;

    store_req_t        req;
    entry_t            rd_data;

    assign asid_next = cfg_we ? cfg_wdata : asid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            asid_reg <= '0;
        end
        else
        begin
            asid_reg <= asid_next;
        end
    end

    // entry memory, cleared through valid bits
    utlb_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rd_data (rd_data)
    );

    // sequencer with the shared compare unit
    utlb_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .entry_index  (entry_index),
        .associative  (associative),
        .write_data   (write_data),
        .current_asid (asid_reg),
        .req          (req),
        .rd_data      (rd_data),
        .done         (done),
        .read_data    (read_data),
        .hit          (hit),
        .error        (error)
    );

endmodule
